// ===== sv/fmrq_pkg.sv =====
// Shared types and constants for the framed message ring queue.
`timescale 1ns / 1ps

package fmrq_pkg;

	// Item field widths
	localparam int FUNC_W   = 2;
	localparam int WORD_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 11;

	// Bytes in a stored message header, and the width of the sequence counter
	localparam int HDR_BYTES = 4;
	localparam int CNT_W     = 3;

	// Function codes
	localparam logic [FUNC_W-1:0] FN_PUSH_BEGIN = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BYTE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_POP_BYTE   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_DROP       = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MSG    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PUSH_OPEN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_PUSH   = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                accept;
		logic                set_status;
		logic [STATUS_W-1:0] status;
		logic                head_direct;
		logic                open_push;
		logic                wr_hdr;
		logic [1:0]          sel;
		logic                wr_data;
		logic                rd_issue;
		logic                off_inc;
		logic                cap_byte;
		logic                drop_calc;
		logic                drop_apply;
		logic                next;
		logic                clear;
		logic                hdr_cap;
		logic                hdr_load;
	} dp_cmd_t;

	// Status flags from the datapath to the controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              push_open;
		logic              head_valid;
		logic              too_big;
		logic              queue_empty;
		logic              off_lt_size;
		logic              fill_lt_hdr;
	} dp_stat_t;

endpackage

// ===== sv/framed_message_ring_queue.sv =====
// Top level of the framed message ring queue: controller and datapath.
// A rejected item, a push_byte or a push_begin that becomes the head finishes in the
// evaluate state; a push_begin that stores a header then writes its four bytes, a pop_byte
// waits for its read byte, and a pop or drop that ends the message may load the next
// header (four reads on the single memory read port).
// A new item is taken in the cycle the done strobe shows. Reset clears indices,
// fill count and head registers at once; the ring contents need no clearing.
`timescale 1ns / 1ps

module framed_message_ring_queue import fmrq_pkg::*; #(
	parameter int RING_BYTES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [WORD_W-1:0]   msg_type,
	input  logic [WORD_W-1:0]   msg_length,
	input  logic [BYTE_W-1:0]   data_byte,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   read_byte,
	output logic                byte_valid,
	output logic                last_of_message,
	output logic                ready_res,
	output logic [WORD_W-1:0]   head_type_out,
	output logic [WORD_W-1:0]   head_size_out,
	output logic [FREE_W-1:0]   free_bytes
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing of each operation
	fmrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Storage and arithmetic
	fmrq_dp #(
		.RING_BYTES (RING_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (func),
		.msg_type        (msg_type),
		.msg_length      (msg_length),
		.data_byte       (data_byte),
		.status          (status),
		.read_byte       (read_byte),
		.byte_valid      (byte_valid),
		.last_of_message (last_of_message),
		.ready_res       (ready_res),
		.head_type_out   (head_type_out),
		.head_size_out   (head_size_out),
		.free_bytes      (free_bytes)
	);

endmodule

// ===== sv/fmrq_ctrl.sv =====
// Controller state machine that sequences each queue operation.
`timescale 1ns / 1ps

module fmrq_ctrl import fmrq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EVAL    = 3'd1;
	localparam logic [2:0] S_WRHDR   = 3'd2;
	localparam logic [2:0] S_POPWAIT = 3'd3;
	localparam logic [2:0] S_DROP    = 3'd4;
	localparam logic [2:0] S_NEXT    = 3'd5;
	localparam logic [2:0] S_HDR     = 3'd6;

	localparam logic [CNT_W-1:0] CNT_HDR_LAST = CNT_W'(HDR_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_HDR_END  = CNT_W'(HDR_BYTES);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q;
	logic             fin;

	// Next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				case (stat.func)
					FN_PUSH_BEGIN: begin
						if (stat.push_open) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_PUSH_OPEN;
							fin            = 1'b1;
						end else if (stat.too_big) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_TOO_BIG;
							fin            = 1'b1;
						end else if (stat.queue_empty) begin
							cmd.head_direct = 1'b1;
							cmd.open_push   = 1'b1;
							fin             = 1'b1;
						end else begin
							state_d = S_WRHDR;
							cnt_d   = '0;
						end
					end
					FN_PUSH_BYTE: begin
						if (!stat.push_open) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NO_PUSH;
						end else begin
							cmd.wr_data = 1'b1;
						end
						fin = 1'b1;
					end
					default: begin
						if (stat.push_open) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_PUSH_OPEN;
							fin            = 1'b1;
						end else if (!stat.head_valid) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NO_MSG;
							fin            = 1'b1;
						end else if (stat.func == FN_POP_BYTE) begin
							if (stat.off_lt_size) begin
								cmd.rd_issue = 1'b1;
								cmd.off_inc  = 1'b1;
								state_d      = S_POPWAIT;
							end else begin
								state_d = S_NEXT;
							end
						end else begin
							cmd.drop_calc = 1'b1;
							state_d       = S_DROP;
						end
					end
				endcase
			end
			S_WRHDR: begin
				cmd.wr_hdr = 1'b1;
				cmd.sel    = cnt_q[1:0];
				if (cnt_q == CNT_HDR_LAST) begin
					cmd.open_push = 1'b1;
					fin           = 1'b1;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_POPWAIT: begin
				cmd.cap_byte = 1'b1;
				if (!stat.off_lt_size) begin
					state_d = S_NEXT;
				end else begin
					fin = 1'b1;
				end
			end
			S_DROP: begin
				cmd.drop_apply = 1'b1;
				state_d        = S_NEXT;
			end
			S_NEXT: begin
				cmd.next = 1'b1;
				if (stat.fill_lt_hdr) begin
					cmd.clear = 1'b1;
					fin       = 1'b1;
				end else begin
					state_d = S_HDR;
					cnt_d   = '0;
				end
			end
			S_HDR: begin
				// Reads issue in the first four steps; each byte is captured from the read register, the last at the load
				if (cnt_q < CNT_HDR_END) begin
					cmd.rd_issue = 1'b1;
				end
				if (cnt_q != '0 && cnt_q < CNT_HDR_END) begin
					cmd.hdr_cap = 1'b1;
				end
				if (cnt_q == CNT_HDR_END) begin
					cmd.hdr_load = 1'b1;
					fin          = 1'b1;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== sv/fmrq_dp.sv =====
// Datapath of the queue: byte ring memory, indices, fill count and head registers.
`timescale 1ns / 1ps

module fmrq_dp import fmrq_pkg::*; #(
	parameter int RING_BYTES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [FUNC_W-1:0]   func,
	input  logic [WORD_W-1:0]   msg_type,
	input  logic [WORD_W-1:0]   msg_length,
	input  logic [BYTE_W-1:0]   data_byte,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   read_byte,
	output logic                byte_valid,
	output logic                last_of_message,
	output logic                ready_res,
	output logic [WORD_W-1:0]   head_type_out,
	output logic [WORD_W-1:0]   head_size_out,
	output logic [FREE_W-1:0]   free_bytes
);

	localparam int IW = $clog2(RING_BYTES);
	localparam int FW = $clog2(RING_BYTES + 1);
	localparam int CW = (FW > WORD_W) ? FW : WORD_W;

	localparam logic [IW-1:0] IDX_LAST = IW'(RING_BYTES - 1);
	localparam logic [FW-1:0] RING_F   = FW'(RING_BYTES);
	localparam logic [FW-1:0] HDR_F    = FW'(HDR_BYTES);
	localparam logic [FW:0]   RING_F1  = (FW+1)'(RING_BYTES);
	localparam logic [IW:0]   RING_I1  = (IW+1)'(RING_BYTES);

	// Ring memory
	logic [BYTE_W-1:0] ring_mem [RING_BYTES];

	// Latched item
	logic [FUNC_W-1:0] func_q;
	logic [WORD_W-1:0] type_q;
	logic [WORD_W-1:0] len_q;
	logic [BYTE_W-1:0] dbyte_q;

	// Queue state
	logic [IW-1:0]     rd_idx_q;
	logic [IW-1:0]     wr_idx_q;
	logic [FW-1:0]     fill_q;
	logic              head_valid_q;
	logic [WORD_W-1:0] head_type_q;
	logic [WORD_W-1:0] head_size_q;
	logic [WORD_W-1:0] head_off_q;
	logic [WORD_W-1:0] push_rem_q;
	logic              push_open_q;

	// Working and result registers
	logic [BYTE_W-1:0]   rdata_q;
	logic [23:0]         hdr_q;
	logic [FW-1:0]       rest_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [BYTE_W-1:0]   res_byte_q;
	logic                res_bvalid_q;
	logic                res_last_q;

	logic              full;
	logic              mem_we;
	logic [BYTE_W-1:0] wdata;
	logic [FW:0]       used_w;
	logic [FW-1:0]     free_w;
	logic [IW-1:0]     wr_idx_inc;
	logic [IW-1:0]     rd_idx_inc;
	logic [WORD_W-1:0] rest_raw;
	logic [FW-1:0]     rest_min;
	logic [IW-1:0]     rest_m;
	logic [IW:0]       drop_sum;
	logic [IW-1:0]     drop_idx;
	logic [WORD_W-1:0] push_rem_dec;
	logic [31:0]       hdr_full;

	// Free space and write data selection
	assign full   = (fill_q >= RING_F);
	assign mem_we = (cmd.wr_hdr || cmd.wr_data) && !full;
	assign used_w = {1'b0, fill_q} + (FW+1)'(HDR_BYTES);
	assign free_w = (RING_F1 > used_w) ? FW'(RING_F1 - used_w) : '0;

	always_comb begin
		if (cmd.wr_data) begin
			wdata = dbyte_q;
		end else begin
			case (cmd.sel)
				2'd0:    wdata = type_q[7:0];
				2'd1:    wdata = type_q[15:8];
				2'd2:    wdata = len_q[7:0];
				default: wdata = len_q[15:8];
			endcase
		end
	end

	// Index increments with wrap
	assign wr_idx_inc = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + IW'(1);
	assign rd_idx_inc = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + IW'(1);

	// Drop: unread part of the head message, limited to what is stored
	assign rest_raw = (head_size_q > head_off_q) ? head_size_q - head_off_q : '0;
	assign rest_min = (CW'(rest_raw) > CW'(fill_q)) ? fill_q : FW'(rest_raw);
	assign rest_m   = (rest_q == RING_F) ? '0 : IW'(rest_q);
	assign drop_sum = {1'b0, rd_idx_q} + {1'b0, rest_m};
	assign drop_idx = (drop_sum >= RING_I1) ? IW'(drop_sum - RING_I1) : IW'(drop_sum);

	assign push_rem_dec = (push_rem_q != '0) ? push_rem_q - WORD_W'(1) : '0;
	assign hdr_full     = {rdata_q, hdr_q};

	// Memory ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_idx_q] <= wdata;
		end
		if (cmd.rd_issue) begin
			rdata_q <= ring_mem[rd_idx_q];
		end
	end

	// Latched item, working and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q       <= func;
			type_q       <= msg_type;
			len_q        <= msg_length;
			dbyte_q      <= data_byte;
			res_status_q <= ST_OK;
			res_byte_q   <= '0;
			res_bvalid_q <= 1'b0;
			res_last_q   <= 1'b0;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.cap_byte) begin
			res_byte_q   <= rdata_q;
			res_bvalid_q <= 1'b1;
		end
		if (cmd.next) begin
			res_last_q <= 1'b1;
		end
		if (cmd.hdr_cap) begin
			hdr_q <= {rdata_q, hdr_q[23:8]};
		end
		if (cmd.drop_calc) begin
			rest_q <= rest_min;
		end
	end

	// Queue state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			wr_idx_q     <= '0;
			fill_q       <= '0;
			head_valid_q <= 1'b0;
			head_type_q  <= '0;
			head_size_q  <= '0;
			head_off_q   <= '0;
			push_rem_q   <= '0;
			push_open_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				wr_idx_q <= wr_idx_inc;
			end

			if (cmd.rd_issue) begin
				rd_idx_q <= rd_idx_inc;
			end else if (cmd.drop_apply) begin
				rd_idx_q <= drop_idx;
			end else if (cmd.clear) begin
				rd_idx_q <= wr_idx_q;
			end

			if (mem_we) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.rd_issue) begin
				if (fill_q != '0) begin
					fill_q <= fill_q - FW'(1);
				end
			end else if (cmd.drop_apply) begin
				fill_q <= fill_q - rest_q;
			end else if (cmd.clear) begin
				fill_q <= '0;
			end

			if (cmd.head_direct) begin
				head_valid_q <= 1'b1;
				head_type_q  <= type_q;
				head_size_q  <= len_q;
			end else if (cmd.clear) begin
				head_valid_q <= 1'b0;
				head_type_q  <= '0;
				head_size_q  <= '0;
			end else if (cmd.hdr_load) begin
				head_valid_q <= 1'b1;
				head_type_q  <= hdr_full[15:0];
				head_size_q  <= hdr_full[31:16];
			end

			if (cmd.head_direct || cmd.next) begin
				head_off_q <= '0;
			end else if (cmd.off_inc) begin
				head_off_q <= head_off_q + WORD_W'(1);
			end

			if (cmd.open_push) begin
				push_rem_q  <= len_q;
				push_open_q <= (len_q != '0);
			end else if (cmd.wr_data) begin
				push_rem_q  <= push_rem_dec;
				push_open_q <= (push_rem_dec != '0);
			end
		end
	end

	// Status to the controller
	assign stat.func        = func_q;
	assign stat.push_open   = push_open_q;
	assign stat.head_valid  = head_valid_q;
	assign stat.too_big     = (CW'(len_q) > CW'(free_w));
	assign stat.queue_empty = (fill_q == '0) && !head_valid_q;
	assign stat.off_lt_size = (head_off_q < head_size_q);
	assign stat.fill_lt_hdr = (fill_q < HDR_F);

	// Result ports
	assign status          = res_status_q;
	assign read_byte       = res_byte_q;
	assign byte_valid      = res_bvalid_q;
	assign last_of_message = res_last_q;
	assign ready_res       = head_valid_q && !push_open_q;
	assign head_type_out   = head_valid_q ? head_type_q : '0;
	assign head_size_out   = head_valid_q ? head_size_q : '0;
	assign free_bytes      = FREE_W'(free_w);

endmodule

// ===== sv/fmrq_checker.sv =====
// Port-level checks for the framed message ring queue, bound to the top level.
`timescale 1ns / 1ps

module fmrq_checker import fmrq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic                byte_valid,
	input logic                last_of_message
);

	// An accepted transfer keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// A result is only shown once the block has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A popped byte only comes with a successful status.
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && byte_valid |-> status == ST_OK)
		else $error("payload byte with an error status");

	// A refused operation neither returns a byte nor ends a message.
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> !byte_valid && !last_of_message)
		else $error("refused operation changed the head message");

	// Two results never come in consecutive cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in back-to-back cycles");

endmodule

bind framed_message_ring_queue fmrq_checker u_fmrq_checker (.*);
